// ===== hdl/ghwr_pkg.sv =====
// ----------------------------------------------------------------------------
// ghwr_pkg
// Shared types and constants of the half-weighting restriction block.
// ----------------------------------------------------------------------------
package ghwr_pkg;

  localparam int unsigned MAX_COARSE_WIDTH_DEF = 512;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned SUM_W      = VALUE_W + 3;
  localparam int unsigned CW_W       = 10;
  localparam int unsigned CH_W       = 12;
  localparam int unsigned FY_W       = CH_W + 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  localparam int unsigned MID_DEPTH  = 4;
  localparam int unsigned OUT_DEPTH  = 4;

  localparam logic [CW_W-1:0] CW_RESET = CW_W'(512);
  localparam logic [CH_W-1:0] CH_RESET = CH_W'(512);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COARSE_WIDTH  = 2'd0,
    REG_COARSE_HEIGHT = 2'd1,
    REG_XMAX_WEIGHTED = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_COPY     = 2'd0,
    ST_INTERIOR = 2'd1,
    ST_EDGE     = 2'd2
  } stencil_e;

  typedef struct packed {
    logic [CW_W-1:0] coarse_width;
    logic [CH_W-1:0] coarse_height;
    logic            xmax_weighted;
  } cfg_t;

  // one classified coarse point with its stencil operands
  typedef struct packed {
    stencil_e             kind;
    logic                 frame_last;
    logic [VALUE_W-1:0]   center;
    logic [VALUE_W-1:0]   north;
    logic [VALUE_W-1:0]   south;
    logic [VALUE_W-1:0]   west;
    logic [VALUE_W-1:0]   east;
  } mid_entry_t;

  typedef struct packed {
    logic [VALUE_W-1:0] coarse_value;
    logic               frame_last;
  } res_t;

endpackage

// ===== hdl/ghwr_fifo.sv =====
// ----------------------------------------------------------------------------
// ghwr_fifo
// Small register queue with first-word fall-through read and an occupancy
// count. The writer checks the count before pushing.
// ----------------------------------------------------------------------------
module ghwr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [WIDTH-1:0]               data_i,
  input  logic                           pop_i,
  output logic [WIDTH-1:0]               data_o,
  output logic                           empty_o,
  output logic [$clog2(DEPTH+1)-1:0]     count_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/ghwr_front.sv =====
// ----------------------------------------------------------------------------
// ghwr_front
// Fine-grid position counters, two-row line buffer and stencil classifier.
// Every accepted sample updates the line buffer; samples that complete a
// coarse point leave as one queue entry in the next cycle.
// ----------------------------------------------------------------------------
module ghwr_front #(
  parameter int unsigned MAX_COARSE_WIDTH = ghwr_pkg::MAX_COARSE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ghwr_pkg::cfg_t                    cfg_i,
  input  logic                              in_accept_i,
  input  logic [ghwr_pkg::VALUE_W-1:0]      fine_value_i,
  output logic                              entry_valid_o,
  output ghwr_pkg::mid_entry_t              entry_o
);

  localparam int unsigned VW         = ghwr_pkg::VALUE_W;
  localparam int unsigned FY_W       = ghwr_pkg::FY_W;
  localparam int unsigned LINE_DEPTH = 2 * MAX_COARSE_WIDTH + 1;
  localparam int unsigned FX_W       = $clog2(LINE_DEPTH);
  localparam int unsigned CMP_W      = (FX_W > ghwr_pkg::CW_W) ? FX_W : ghwr_pkg::CW_W;
  localparam logic [FX_W-1:0]  LastAddr = FX_W'(LINE_DEPTH - 1);
  localparam logic [CMP_W-1:0] MaxCw    = CMP_W'(MAX_COARSE_WIDTH);

  // each word holds {upper row, middle row} of one fine column
  logic [2*VW-1:0] line_mem [LINE_DEPTH];

  logic [FX_W-1:0]  fx_q, fx_d;
  logic [FY_W-1:0]  fy_q, fy_d;
  logic [CMP_W-1:0] cw_ext, w_clamp;
  logic [FX_W-1:0]  last_x;
  logic [FY_W-1:0]  last_y;
  logic             x_end, y_end, emit, sel_south;
  logic [FX_W-1:0]  east_addr;
  ghwr_pkg::stencil_e kind;

  logic                s1_valid_q, s1_emit_q;
  logic [FX_W-1:0]     s1_addr_q;
  logic [VW-1:0]       s1_sample_q;
  ghwr_pkg::stencil_e  s1_kind_q;
  logic                s1_sel_south_q, s1_last_q;
  logic [2*VW-1:0]     rd_word_q, fwd_word_q;
  logic [VW-1:0]       rd_east_q, prev_center_q;
  logic                fwd_cen_q, fwd_east_q;

  logic [2*VW-1:0]     word, wr_word;
  logic [VW-1:0]       north, center, east;

  // S0: position decode
  assign cw_ext  = CMP_W'(cfg_i.coarse_width);
  assign w_clamp = (cw_ext > MaxCw) ? MaxCw : cw_ext;
  assign last_x  = {w_clamp[FX_W-2:0], 1'b0};
  assign last_y  = {cfg_i.coarse_height, 1'b0};
  assign x_end   = (fx_q >= last_x);
  assign y_end   = (fy_q >= last_y);
  assign emit    = !fx_q[0] && (fy_q[0] || y_end);
  assign east_addr = (fx_q == LastAddr) ? fx_q : fx_q + FX_W'(1);

  always_comb begin
    kind      = ghwr_pkg::ST_COPY;
    sel_south = 1'b0;
    priority if (y_end) begin
      sel_south = 1'b1;
    end else if (fy_q == FY_W'(1)) begin
      kind = ghwr_pkg::ST_COPY;
    end else if (fx_q == '0) begin
      kind = ghwr_pkg::ST_COPY;
    end else if (x_end) begin
      kind = cfg_i.xmax_weighted ? ghwr_pkg::ST_EDGE : ghwr_pkg::ST_COPY;
    end else begin
      kind = ghwr_pkg::ST_INTERIOR;
    end
  end

  always_comb begin
    fx_d = fx_q;
    fy_d = fy_q;
    if (in_accept_i) begin
      if (x_end) begin
        fx_d = '0;
        fy_d = y_end ? '0 : fy_q + FY_W'(1);
      end else begin
        fx_d = fx_q + FX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q       <= '0;
      fy_q       <= '0;
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else begin
      fx_q       <= fx_d;
      fy_q       <= fy_d;
      s1_valid_q <= in_accept_i;
      s1_emit_q  <= in_accept_i && emit;
    end
  end

  // S1: line data; the write-back of the previous sample is bypassed when a
  // back-to-back sample reads the column being written
  assign word    = fwd_cen_q ? fwd_word_q : rd_word_q;
  assign north   = word[2*VW-1:VW];
  assign center  = word[VW-1:0];
  assign east    = fwd_east_q ? fwd_word_q[VW-1:0] : rd_east_q;
  assign wr_word = {center, s1_sample_q};

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      line_mem[s1_addr_q] <= wr_word;
    end
    if (in_accept_i) begin
      rd_word_q <= line_mem[fx_q];
      rd_east_q <= line_mem[east_addr][VW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      s1_addr_q      <= fx_q;
      s1_sample_q    <= fine_value_i;
      s1_kind_q      <= kind;
      s1_sel_south_q <= sel_south;
      s1_last_q      <= x_end && y_end;
      fwd_cen_q      <= s1_valid_q && (fx_q == s1_addr_q);
      fwd_east_q     <= s1_valid_q && (east_addr == s1_addr_q);
      fwd_word_q     <= wr_word;
    end
    // west neighbour is the center of the sample one column to the left
    if (s1_valid_q) begin
      prev_center_q <= center;
    end
  end

  assign entry_valid_o      = s1_emit_q;
  assign entry_o.kind       = s1_kind_q;
  assign entry_o.frame_last = s1_last_q;
  assign entry_o.center     = s1_sel_south_q ? s1_sample_q : center;
  assign entry_o.north      = north;
  assign entry_o.south      = s1_sample_q;
  assign entry_o.west       = prev_center_q;
  assign entry_o.east       = east;

endmodule

// ===== hdl/ghwr_back.sv =====
// ----------------------------------------------------------------------------
// ghwr_back
// Stencil arithmetic: partial sums, final add with floor shift by 3, then
// push into the result queue. Issue is credit based on queue space.
// ----------------------------------------------------------------------------
module ghwr_back (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  ghwr_pkg::mid_entry_t                      entry_i,
  input  logic                                      entry_empty_i,
  output logic                                      entry_pop_o,
  input  logic [$clog2(ghwr_pkg::OUT_DEPTH+1)-1:0]  out_count_i,
  output logic                                      res_push_o,
  output ghwr_pkg::res_t                            res_o
);

  localparam int unsigned VW     = ghwr_pkg::VALUE_W;
  localparam int unsigned SW     = ghwr_pkg::SUM_W;
  localparam int unsigned OCNT_W = $clog2(ghwr_pkg::OUT_DEPTH + 1);

  logic              b1_valid_q, b2_valid_q;
  logic              b1_copy_q, b1_last_q;
  logic [VW-1:0]     b1_center_q;
  logic [SW-1:0]     b1_a_q, b1_b_q;
  ghwr_pkg::res_t    res_q;

  logic [OCNT_W:0]   inflight;
  logic [SW-1:0]     c4, n_ext, s_ext, w_ext, e_ext, w2, sum_a, sum_b, sum;

  assign inflight = {1'b0, out_count_i} + (OCNT_W+1)'(b1_valid_q) + (OCNT_W+1)'(b2_valid_q);
  assign entry_pop_o = !entry_empty_i && (inflight < (OCNT_W+1)'(ghwr_pkg::OUT_DEPTH));

  assign c4    = {entry_i.center[VW-1], entry_i.center, 2'b00};
  assign n_ext = {{3{entry_i.north[VW-1]}}, entry_i.north};
  assign s_ext = {{3{entry_i.south[VW-1]}}, entry_i.south};
  assign w_ext = {{3{entry_i.west[VW-1]}}, entry_i.west};
  assign e_ext = {{3{entry_i.east[VW-1]}}, entry_i.east};
  assign w2    = {{2{entry_i.west[VW-1]}}, entry_i.west, 1'b0};
  assign sum_a = c4 + n_ext + s_ext;
  assign sum_b = (entry_i.kind == ghwr_pkg::ST_EDGE) ? w2 : w_ext + e_ext;
  assign sum   = b1_a_q + b1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
    end else begin
      b1_valid_q <= entry_pop_o;
      b2_valid_q <= b1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_pop_o) begin
      b1_copy_q   <= (entry_i.kind == ghwr_pkg::ST_COPY);
      b1_last_q   <= entry_i.frame_last;
      b1_center_q <= entry_i.center;
      b1_a_q      <= sum_a;
      b1_b_q      <= sum_b;
    end
    if (b1_valid_q) begin
      // arithmetic shift right by three floors toward minus infinity
      res_q.coarse_value <= b1_copy_q ? b1_center_q : sum[SW-1:3];
      res_q.frame_last   <= b1_last_q;
    end
  end

  assign res_push_o = b2_valid_q;
  assign res_o      = res_q;

endmodule

// ===== hdl/grid_half_weighting_restriction.sv =====
// ----------------------------------------------------------------------------
// grid_half_weighting_restriction
// Streams a fine grid in and the half-weighted coarse grid out.
// ----------------------------------------------------------------------------
// Usage:
//   Fine samples (signed Q16.16, raster order, x fastest) enter through
//   push/full; a transaction completes when push is high and full is low.
//   Coarse samples leave in raster order through empty/pop; the oldest one is
//   on coarse_value_o/frame_last_o while empty is low, and frame_last_o marks
//   the final point of a grid. Registers (coarse_width, coarse_height,
//   xmax_weighted) are written through the cfg channel, which is always ready;
//   write them only while the block is drained.
// Timing:
//   One fine sample per cycle sustained while full stays low. A sample that
//   completes a coarse point reaches the outputs through the line buffer
//   read, the classify queue, two adder stages and the result queue.
//   The line buffer is read at the transaction and written back in the cycle
//   after, with a bypass for back-to-back samples, so one sample per cycle.
// Reset and stalls:
//   Reset clears the position counters, queues and registers (width and
//   height 512, one-sided edge off); line-buffer contents stay undefined.
//   When pop is held low the result queue fills, the adder stages stop
//   issuing, the classify queue fills, and full rises.
// ----------------------------------------------------------------------------
module grid_half_weighting_restriction #(
  parameter int unsigned MAX_COARSE_WIDTH = ghwr_pkg::MAX_COARSE_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [ghwr_pkg::VALUE_W-1:0]       fine_value_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [ghwr_pkg::VALUE_W-1:0]       coarse_value_o,
  output logic                               frame_last_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ghwr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ghwr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned MCNT_W = $clog2(ghwr_pkg::MID_DEPTH + 1);
  localparam int unsigned OCNT_W = $clog2(ghwr_pkg::OUT_DEPTH + 1);
  localparam int unsigned MID_W  = $bits(ghwr_pkg::mid_entry_t);
  localparam int unsigned RES_W  = $bits(ghwr_pkg::res_t);

  ghwr_pkg::cfg_t       cfg_q;
  logic                 in_accept;
  logic                 mid_push, mid_pop, mid_empty;
  logic [MCNT_W-1:0]    mid_count;
  ghwr_pkg::mid_entry_t mid_in, mid_out;
  logic [MID_W-1:0]     mid_out_bits;
  logic                 res_push;
  ghwr_pkg::res_t       res_in, res_out;
  logic [RES_W-1:0]     res_out_bits;
  logic [OCNT_W-1:0]    out_count;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coarse_width  <= ghwr_pkg::CW_RESET;
      cfg_q.coarse_height <= ghwr_pkg::CH_RESET;
      cfg_q.xmax_weighted <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (ghwr_pkg::cfg_reg_e'(cfg_index_i))
        ghwr_pkg::REG_COARSE_WIDTH: begin
          cfg_q.coarse_width <= cfg_data_i[ghwr_pkg::CW_W-1:0];
        end
        ghwr_pkg::REG_COARSE_HEIGHT: begin
          cfg_q.coarse_height <= cfg_data_i[ghwr_pkg::CH_W-1:0];
        end
        ghwr_pkg::REG_XMAX_WEIGHTED: begin
          cfg_q.xmax_weighted <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // one slot is held back for the sample still in the line-buffer stage
  assign full      = (mid_count >= MCNT_W'(ghwr_pkg::MID_DEPTH - 1));
  assign in_accept = push && !full;

  ghwr_front #(
    .MAX_COARSE_WIDTH (MAX_COARSE_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_accept_i   (in_accept),
    .fine_value_i  (fine_value_i),
    .entry_valid_o (mid_push),
    .entry_o       (mid_in)
  );

  ghwr_fifo #(
    .WIDTH (MID_W),
    .DEPTH (ghwr_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .pop_i   (mid_pop),
    .data_o  (mid_out_bits),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  assign mid_out = ghwr_pkg::mid_entry_t'(mid_out_bits);

  ghwr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (mid_out),
    .entry_empty_i (mid_empty),
    .entry_pop_o   (mid_pop),
    .out_count_i   (out_count),
    .res_push_o    (res_push),
    .res_o         (res_in)
  );

  ghwr_fifo #(
    .WIDTH (RES_W),
    .DEPTH (ghwr_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_out_bits),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign res_out        = ghwr_pkg::res_t'(res_out_bits);
  assign coarse_value_o = res_out.coarse_value;
  assign frame_last_o   = res_out.frame_last;

  // classify queue never overflows: the full threshold covers the in-flight sample
  a_mid_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_push && !mid_pop) |-> (mid_count < MCNT_W'(ghwr_pkg::MID_DEPTH)))
    else $error("classify queue overflow");

  // result queue never overflows: adder issue credit accounts for both stages
  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && !(pop && !empty)) |-> (out_count < OCNT_W'(ghwr_pkg::OUT_DEPTH)))
    else $error("result queue overflow");

  // a queued point reaches the result queue through both adder stages after it is issued
  a_issue_to_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> ##2 res_push)
    else $error("issued point lost in adder stages");

endmodule

// ===== tb/ghwr_checker.sv =====
// ----------------------------------------------------------------------------
// ghwr_checker
// Scoreboard for the half-weighting restriction block: tracks register
// writes, predicts every coarse sample from the accepted fine samples and
// compares each popped sample, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ghwr_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  logic                              full_i,
  input  logic [ghwr_pkg::VALUE_W-1:0]      fine_value_i,
  input  logic                              empty_i,
  input  logic                              pop_i,
  input  logic [ghwr_pkg::VALUE_W-1:0]      coarse_value_i,
  input  logic                              frame_last_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [ghwr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ghwr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output int unsigned                       mismatch_count_o,
  output int unsigned                       pending_o,
  output int unsigned                       results_o,
  output int unsigned                       stencil_results_o
);

  localparam int unsigned MAX_W      = ghwr_pkg::MAX_COARSE_WIDTH_DEF;
  localparam int unsigned LINE_DEPTH = 2 * MAX_W + 1;
  localparam int unsigned PRINT_CAP  = 20;

  logic [31:0]             upper_row  [LINE_DEPTH];
  logic [31:0]             middle_row [LINE_DEPTH];
  logic [10:0]             col;
  logic [12:0]             row;
  logic [ghwr_pkg::CW_W-1:0] grid_width;
  logic [ghwr_pkg::CH_W-1:0] grid_height;
  logic                    edge_weighted;
  ghwr_pkg::res_t          coarse_q [$];
  int unsigned             mismatches;
  int unsigned             results_seen;
  int unsigned             stencil_hits;
  int unsigned             idx;

  assign mismatch_count_o  = mismatches;
  assign results_o         = results_seen;
  assign stencil_results_o = stencil_hits;

  initial begin
    mismatches   = 0;
    results_seen = 0;
    stencil_hits = 0;
  end

  function automatic longint widen(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  task automatic restrict_sample(input logic [31:0] sample);
    int unsigned w, last_x, last_y, fx, fy, cx;
    logic [31:0] north, center, value;
    longint      acc;
    w      = (grid_width > MAX_W) ? MAX_W : grid_width;
    last_x = 2 * w;
    last_y = 2 * grid_height;
    fx     = (col >= LINE_DEPTH) ? LINE_DEPTH - 1 : col;
    fy     = row;
    north  = upper_row[fx];
    center = middle_row[fx];
    upper_row[fx]  = center;
    middle_row[fx] = sample;
    // a coarse point closes on an even column of an odd row or of the last row
    if (fx[0] == 1'b0 && (fy[0] == 1'b1 || fy >= last_y)) begin
      cx = fx >> 1;
      if (fy >= last_y) begin
        value = sample;
      end else if (fy == 1 || cx == 0) begin
        value = center;
      end else if (cx >= w) begin
        if (edge_weighted) begin
          acc   = 4 * widen(center) + 2 * widen(upper_row[fx-1]) + widen(north)
                  + widen(sample);
          acc   = acc >>> 3;
          value = acc[31:0];
          stencil_hits++;
        end else begin
          value = center;
        end
      end else begin
        acc   = 4 * widen(center) + widen(upper_row[fx-1]) + widen(middle_row[fx+1])
                + widen(north) + widen(sample);
        acc   = acc >>> 3;
        value = acc[31:0];
        stencil_hits++;
      end
      coarse_q.push_back('{coarse_value: value,
                           frame_last: (fx >= last_x && fy >= last_y)});
    end
    if (fx >= last_x) begin
      col = '0;
      row = (fy >= last_y) ? '0 : 13'(fy + 1);
    end else begin
      col = 11'(fx + 1);
    end
  endtask

  task automatic check_coarse(input logic [31:0] got_value, input logic got_last);
    ghwr_pkg::res_t want;
    results_seen++;
    if (coarse_q.size() == 0) begin
      report_mismatch($sformatf("coarse sample %h with nothing expected", got_value));
    end else begin
      want = coarse_q.pop_front();
      if (got_value !== want.coarse_value) begin
        report_mismatch($sformatf("result %0d coarse_value %h, expected %h",
                                  results_seen, got_value, want.coarse_value));
      end
      if (got_last !== want.frame_last) begin
        report_mismatch($sformatf("result %0d frame_last %b, expected %b",
                                  results_seen, got_last, want.frame_last));
      end
    end
  endtask

  task automatic apply_write(input logic [ghwr_pkg::CFG_IDX_W-1:0] index,
                             input logic [ghwr_pkg::CFG_DATA_W-1:0] data);
    case (ghwr_pkg::cfg_reg_e'(index))
      ghwr_pkg::REG_COARSE_WIDTH:  grid_width    = data[ghwr_pkg::CW_W-1:0];
      ghwr_pkg::REG_COARSE_HEIGHT: grid_height   = data[ghwr_pkg::CH_W-1:0];
      ghwr_pkg::REG_XMAX_WEIGHTED: edge_weighted = data[0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (idx = 0; idx < LINE_DEPTH; idx++) begin
        upper_row[idx]  = '0;
        middle_row[idx] = '0;
      end
      col           = '0;
      row           = '0;
      grid_width    = ghwr_pkg::CW_RESET;
      grid_height   = ghwr_pkg::CH_RESET;
      edge_weighted = 1'b0;
      coarse_q.delete();
      pending_o <= 0;
    end else begin
      if (pop_i && !empty_i) begin
        check_coarse(coarse_value_i, frame_last_i);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        apply_write(cfg_index_i, cfg_data_i);
      end
      if (push_i && !full_i) begin
        restrict_sample(fine_value_i);
      end
      pending_o <= coarse_q.size();
    end
  end

endmodule

// ===== tb/grid_half_weighting_restriction_tb.sv =====
// ----------------------------------------------------------------------------
// grid_half_weighting_restriction_tb
// Drives fine grids of many sizes through the restriction block with random
// gaps and backpressure, reprograms the grid between frames, and leaves all
// checking to ghwr_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module grid_half_weighting_restriction_tb;

  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned CYCLE_LIMIT     = 4_000_000;
  localparam int unsigned RANDOM_ITEMS    = 900;
  localparam int unsigned MAX_W           = ghwr_pkg::MAX_COARSE_WIDTH_DEF;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              push;
  logic                              full;
  logic [ghwr_pkg::VALUE_W-1:0]      fine_value;
  logic                              empty;
  logic                              pop;
  logic [ghwr_pkg::VALUE_W-1:0]      coarse_value;
  logic                              frame_last;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [ghwr_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [ghwr_pkg::CFG_DATA_W-1:0]   cfg_data;

  int unsigned mismatches, pending, results, stencil_results;
  int unsigned cycle_count   = 0;
  int unsigned samples_sent  = 0;
  int unsigned frames_sent   = 0;
  int unsigned settings_used = 0;
  int unsigned frame_cols    = 1;
  int unsigned frame_rows    = 1;
  bit          push_steady   = 1'b0;
  bit          pop_steady    = 1'b0;

  grid_half_weighting_restriction u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .fine_value_i   (fine_value),
    .empty          (empty),
    .pop            (pop),
    .coarse_value_o (coarse_value),
    .frame_last_o   (frame_last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  ghwr_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_i            (full),
    .fine_value_i      (fine_value),
    .empty_i           (empty),
    .pop_i             (pop),
    .coarse_value_i    (coarse_value),
    .frame_last_i      (frame_last),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .mismatch_count_o  (mismatches),
    .pending_o         (pending),
    .results_o         (results),
    .stencil_results_o (stencil_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d coarse samples outstanding",
               cycle_count, pending);
      $display("grid_half_weighting_restriction_tb failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] extreme_value(input int unsigned k);
    case (k % 5)
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic logic [31:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return extreme_value($urandom_range(0, 4));
      1:       return 32'($urandom_range(0, 255));
      2:       return -32'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  task automatic wait_results();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // close a burst: stop pushing, drain, and give the pipeline time to go idle
  task automatic end_burst();
    push <= 1'b0;
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // all three registers in back-to-back transactions; valid stays high
  task automatic program_grid(input logic [11:0] w_data, input logic [11:0] h_data,
                              input logic [11:0] xw_data);
    int unsigned w_eff;
    cfg_valid <= 1'b1;
    cfg_index <= ghwr_pkg::REG_COARSE_WIDTH;
    cfg_data  <= w_data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= ghwr_pkg::REG_COARSE_HEIGHT;
    cfg_data  <= h_data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= ghwr_pkg::REG_XMAX_WEIGHTED;
    cfg_data  <= xw_data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    w_eff      = (w_data[9:0] > MAX_W) ? MAX_W : w_data[9:0];
    frame_cols = 2 * w_eff + 1;
    frame_rows = 2 * h_data + 1;
    settings_used++;
  endtask

  task automatic send_sample(input logic [31:0] value);
    int unsigned gap;
    bit          hold;
    gap  = push_steady ? 0 : idle_cycles();
    hold = ($urandom_range(0, 299) == 0);
    if (gap != 0 || hold) begin
      push <= 1'b0;
      if (hold) wait_results();
      repeat (gap) @(posedge clk_i);
    end
    push       <= 1'b1;
    fine_value <= value;
    do @(posedge clk_i); while (full);
    samples_sent++;
  endtask

  task automatic send_items(input int unsigned n, input bit use_extremes);
    for (int unsigned k = 0; k < n; k++) begin
      send_sample(use_extremes ? extreme_value(k * 3 + k / 5) : random_sample());
    end
  endtask

  task automatic send_frames(input int unsigned n);
    repeat (n) begin
      send_items(frame_cols * frame_rows, 1'b0);
      frames_sent++;
    end
  endtask

  initial begin : pop_driver
    int unsigned stall;
    stall = 0;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (stall != 0) begin
        pop <= 1'b0;
        stall--;
      end else if (!pop_steady && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        stall = idle_cycles();
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned w, h, directed_items;
    rst_ni     <= 1'b0;
    push       <= 1'b0;
    fine_value <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= ghwr_pkg::REG_COARSE_WIDTH;
    cfg_data   <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-point grid: one corner, copied
    program_grid(12'd0, 12'd0, 12'd0);
    send_items(1, 1'b1);
    frames_sent++;
    end_burst();
    // smallest grid with an interior point and a weighted right edge
    program_grid(12'd2, 12'd2, 12'd1);
    send_items(25, 1'b1);
    frames_sent++;
    end_burst();
    // height cut mid-frame: row 3 becomes the last row and its points copy
    program_grid(12'd1, 12'd2, 12'd0);
    send_items(9, 1'b1);
    end_burst();
    program_grid(12'd1, 12'd0, 12'd0);
    send_items(3, 1'b1);
    frames_sent++;
    end_burst();
    directed_items = samples_sent;

    while (samples_sent < directed_items + RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        w = $urandom_range(7, 24);
        h = $urandom_range(0, 3);
      end else begin
        w = $urandom_range(0, 6);
        h = $urandom_range(0, 6);
      end
      push_steady = ($urandom_range(0, 3) == 0);
      pop_steady  = ($urandom_range(0, 3) == 0);
      // bits above the width field are don't-care and get exercised here
      program_grid({2'($urandom()), 10'(w)}, 12'(h),
                   {11'($urandom()), 1'($urandom())});
      send_frames($urandom_range(1, 3));
      end_burst();
    end

    push_steady = 1'b0;
    pop_steady  = 1'b0;
    // tallest grid, one column wide: only its first rows are sent
    program_grid(12'd0, 12'd4095, 12'd0);
    send_items(40, 1'b0);
    end_burst();

    $display("ran %0d fine samples in %0d frames over %0d grid settings",
             samples_sent, frames_sent, settings_used);
    $display("checked %0d coarse samples, %0d through a weighted stencil",
             results, stencil_results);
    if (mismatches == 0 && pending == 0) begin
      $display("grid_half_weighting_restriction_tb passed");
    end else begin
      $display("%0d mismatches, %0d coarse samples never arrived", mismatches, pending);
      $display("grid_half_weighting_restriction_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ghwr_pkg.sv
hdl/ghwr_fifo.sv
hdl/ghwr_front.sv
hdl/ghwr_back.sv
hdl/grid_half_weighting_restriction.sv
tb/ghwr_checker.sv
tb/grid_half_weighting_restriction_tb.sv
